/* design/caspid_pkg.sv */
// Shared types, constants and the control-store program of the cascaded angle/speed PID.
// Used by every module of the block. It has no dependencies of its own.
package caspid_pkg;

   // Fixed-point formats and state widths.
   localparam int ERR_W   = 18;   // signed error and error difference
   localparam int INT_W   = 32;   // signed integral sums
   localparam int GAIN_W  = 16;   // unsigned Q8.8 gains
   localparam int LIM_W   = 15;   // unsigned output clamps
   localparam int PROD_W  = INT_W + GAIN_W + 1;
   localparam int ACC_W   = 50;
   localparam int PC_W    = 4;

   localparam int ANGLE_INT_LIMIT = 65536;
   localparam int SPEED_INT_LIMIT = 16384;
   localparam int PI_Q12          = 12868;

   // Rounding shifts of the two stages.
   localparam int ANGLE_SHIFT = 20;
   localparam int SPEED_SHIFT = 8;

   // Register indexes of the configuration port.
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_KP      = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_KI      = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_KD      = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_OUT_MAX = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KP      = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KI      = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_KD      = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_OUT_MAX = 4'd7;

   // Program addresses named by the sequencer.
   localparam logic [PC_W-1:0] PC_SPEED = 4'd8;
   localparam logic [PC_W-1:0] PC_LAST  = 4'd14;

   typedef struct packed {
      logic               mode;
      logic signed [15:0] target;
      logic signed [15:0] measured_angle;
      logic signed [15:0] measured_rpm;
   } req_type;

   typedef struct packed {
      logic signed [15:0] drive_command;
      logic signed [15:0] target_speed;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_W-1:0] angle_kp;
      logic [GAIN_W-1:0] angle_ki;
      logic [GAIN_W-1:0] angle_kd;
      logic [LIM_W-1:0]  angle_out_max;
      logic [GAIN_W-1:0] speed_kp;
      logic [GAIN_W-1:0] speed_ki;
      logic [GAIN_W-1:0] speed_kd;
      logic [LIM_W-1:0]  speed_out_max;
   } cfg_type;

   typedef enum logic [2:0] {
      ALU_NOP,
      ALU_A_ERR,
      ALU_A_WRAP,
      ALU_A_UPD,
      ALU_A_OUT,
      ALU_S_ERR,
      ALU_S_UPD,
      ALU_S_INT
   } alu_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_LOAD_RND,
      ACC_ADD_SINT
   } acc_op_type;

   typedef enum logic [1:0] {
      OP_ERR,
      OP_DIF,
      OP_AINT
   } opnd_type;

   typedef enum logic [2:0] {
      G_A_KP,
      G_A_KI,
      G_A_KD,
      G_S_KP,
      G_S_KI,
      G_S_KD
   } gain_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } seq_state_type;

   typedef struct packed {
      alu_op_type       alu;
      acc_op_type       acc;
      logic             mul_en;
      opnd_type         opnd;
      gain_type         gain;
      logic             br_speed;
      logic [PC_W-1:0]  br_target;
      logic             last;
   } ctrl_word_type;

   typedef struct packed {
      logic          load;
      logic          step_en;
      ctrl_word_type word;
   } dp_ctrl_type;

   // Control store: one word per step.
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '0;
      case (pc)
         4'd0: begin
            w.br_speed  = 1'b1;
            w.br_target = PC_SPEED;
         end
         4'd1: w.alu = ALU_A_ERR;
         4'd2: w.alu = ALU_A_WRAP;
         4'd3: begin
            w.alu = ALU_A_UPD;  w.mul_en = 1'b1; w.opnd = OP_ERR;  w.gain = G_A_KP;
         end
         4'd4: begin
            w.acc = ACC_LOAD;   w.mul_en = 1'b1; w.opnd = OP_DIF;  w.gain = G_A_KD;
         end
         4'd5: begin
            w.acc = ACC_ADD;    w.mul_en = 1'b1; w.opnd = OP_AINT; w.gain = G_A_KI;
         end
         4'd6: w.acc = ACC_ADD;
         4'd7: w.alu = ALU_A_OUT;
         4'd8: w.alu = ALU_S_ERR;
         4'd9: begin
            w.alu = ALU_S_UPD;  w.mul_en = 1'b1; w.opnd = OP_ERR;  w.gain = G_S_KI;
         end
         4'd10: begin
            w.acc = ACC_LOAD_RND; w.mul_en = 1'b1; w.opnd = OP_ERR; w.gain = G_S_KP;
         end
         4'd11: begin
            w.alu = ALU_S_INT;  w.acc = ACC_LOAD;
            w.mul_en = 1'b1;    w.opnd = OP_DIF; w.gain = G_S_KD;
         end
         4'd12: w.acc = ACC_ADD;
         4'd13: w.acc = ACC_ADD_SINT;
         4'd14: w.last = 1'b1;
         default: w.last = 1'b1;
      endcase
      return w;
   endfunction

   // Symmetric clamp of a wide value to +-lim, returned as a 16-bit result.
   function automatic logic signed [15:0] clamp_out(input logic signed [ACC_W-1:0] v,
                                                   input logic [LIM_W-1:0] lim);
      logic signed [ACC_W-1:0] pos;
      logic signed [ACC_W-1:0] neg;
      logic signed [15:0]      r;
      pos = signed'(ACC_W'(lim));
      neg = -pos;
      if (v > pos) begin
         r = pos[15:0];
      end else if (v < neg) begin
         r = neg[15:0];
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // floor((v + 2^(sh-1)) / 2^sh)
   function automatic logic signed [ACC_W-1:0] round_shift(input logic signed [ACC_W-1:0] v,
                                                          input int sh);
      logic signed [ACC_W-1:0] w;
      w = v + signed'(ACC_W'(1) << (sh - 1));
      return w >>> sh;
   endfunction

endpackage

/* design/caspid_csr.sv */
// Configuration registers of the cascaded angle/speed PID: gains and output clamps.
// Depends on caspid_pkg for the register indexes and the cfg_type bundle.
module caspid_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [caspid_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                        csr_wdata,
   output caspid_pkg::cfg_type                cfg
);
   import caspid_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (csr_index)
            CSR_ANGLE_KP:      cfg_in.angle_kp      = csr_wdata;
            CSR_ANGLE_KI:      cfg_in.angle_ki      = csr_wdata;
            CSR_ANGLE_KD:      cfg_in.angle_kd      = csr_wdata;
            CSR_ANGLE_OUT_MAX: cfg_in.angle_out_max = csr_wdata[LIM_W-1:0];
            CSR_SPEED_KP:      cfg_in.speed_kp      = csr_wdata;
            CSR_SPEED_KI:      cfg_in.speed_ki      = csr_wdata;
            CSR_SPEED_KD:      cfg_in.speed_kd      = csr_wdata;
            CSR_SPEED_OUT_MAX: cfg_in.speed_out_max = csr_wdata[LIM_W-1:0];
            default:           cfg_in = cfg_ff;   // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* design/caspid_dp.sv */
// Datapath of the cascaded angle/speed PID: error registers, loop state, one shared
// registered multiplier and an accumulator, steered by control words. Uses caspid_pkg.
module caspid_dp (
   input  logic                      clock,
   input  logic                      reset,
   input  caspid_pkg::dp_ctrl_type   ctrl,
   input  caspid_pkg::req_type       req_data,
   input  caspid_pkg::cfg_type       cfg,
   output caspid_pkg::rsp_type       result
);
   import caspid_pkg::*;

   localparam logic signed [ERR_W-1:0]   PI_E      = ERR_W'(PI_Q12);
   localparam logic signed [ERR_W-1:0]   TWO_PI_E  = ERR_W'(2 * PI_Q12);
   localparam logic signed [INT_W:0]     A_LIM     = (INT_W + 1)'(ANGLE_INT_LIMIT);
   localparam logic signed [ACC_W-1:0]   S_LIM     = ACC_W'(SPEED_INT_LIMIT);

   // Item operands, loaded when a word is accepted.
   logic signed [15:0]        target_ff, meas_ff, rpm_ff;
   logic signed [15:0]        tspd_ff, tspd_in;
   // Working registers.
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W-1:0]   dif_ff, dif_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   // Loop state.
   logic signed [ERR_W-1:0]   a_last_ff, a_last_in;
   logic signed [INT_W-1:0]   a_int_ff, a_int_in;
   logic signed [ERR_W-1:0]   s_last_ff, s_last_in;
   logic signed [INT_W-1:0]   s_int_ff, s_int_in;

   logic signed [INT_W-1:0]   opnd;
   logic [GAIN_W-1:0]         gain;
   logic signed [GAIN_W:0]    gain_s;
   logic signed [INT_W:0]     a_sum;
   logic signed [ACC_W-1:0]   s_sum;
   logic signed [ACC_W-1:0]   prod_x;
   ctrl_word_type             w;

   assign w      = ctrl.word;
   assign prod_x = ACC_W'(prod_ff);
   assign a_sum  = (INT_W + 1)'(a_int_ff) + (INT_W + 1)'(err_ff);
   assign s_sum  = ACC_W'(s_int_ff) + acc_ff;

   // Multiplier operand selection.
   always_comb begin
      case (w.opnd)
         OP_ERR:  opnd = INT_W'(err_ff);
         OP_DIF:  opnd = INT_W'(dif_ff);
         OP_AINT: opnd = a_int_ff;
         default: opnd = INT_W'(err_ff);
      endcase
      case (w.gain)
         G_A_KP:  gain = cfg.angle_kp;
         G_A_KI:  gain = cfg.angle_ki;
         G_A_KD:  gain = cfg.angle_kd;
         G_S_KP:  gain = cfg.speed_kp;
         G_S_KI:  gain = cfg.speed_ki;
         G_S_KD:  gain = cfg.speed_kd;
         default: gain = cfg.angle_kp;
      endcase
      gain_s  = signed'({1'b0, gain});
      prod_in = prod_ff;
      if (ctrl.step_en && w.mul_en) begin
         prod_in = opnd * gain_s;
      end
   end

   // Accumulator.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.step_en) begin
         case (w.acc)
            ACC_HOLD:     acc_in = acc_ff;
            ACC_LOAD:     acc_in = prod_x;
            ACC_ADD:      acc_in = acc_ff + prod_x;
            ACC_LOAD_RND: acc_in = round_shift(prod_x, SPEED_SHIFT);
            ACC_ADD_SINT: acc_in = acc_ff + (ACC_W'(s_int_ff) <<< SPEED_SHIFT);
            default:      acc_in = acc_ff;
         endcase
      end
   end

   // Error, state and target speed updates.
   always_comb begin
      err_in    = err_ff;
      dif_in    = dif_ff;
      tspd_in   = tspd_ff;
      a_last_in = a_last_ff;
      a_int_in  = a_int_ff;
      s_last_in = s_last_ff;
      s_int_in  = s_int_ff;
      if (ctrl.load) begin
         tspd_in = req_data.target;   // speed mode uses the target as it is
      end else if (ctrl.step_en) begin
         case (w.alu)
            ALU_NOP: ;
            ALU_A_ERR: err_in = ERR_W'(target_ff) - ERR_W'(meas_ff);
            ALU_A_WRAP: begin
               if (err_ff > PI_E) begin
                  err_in = err_ff - TWO_PI_E;
               end else if (err_ff < -PI_E) begin
                  err_in = err_ff + TWO_PI_E;
               end
            end
            ALU_A_UPD: begin
               dif_in    = err_ff - a_last_ff;
               a_last_in = err_ff;
               if (a_sum > A_LIM) begin
                  a_int_in = INT_W'(A_LIM);
               end else if (a_sum < -A_LIM) begin
                  a_int_in = INT_W'(-A_LIM);
               end else begin
                  a_int_in = a_sum[INT_W-1:0];
               end
            end
            ALU_A_OUT: tspd_in = clamp_out(round_shift(acc_ff, ANGLE_SHIFT),
                                           cfg.angle_out_max);
            ALU_S_ERR: err_in = ERR_W'(tspd_ff) - ERR_W'(rpm_ff);
            ALU_S_UPD: begin
               dif_in    = err_ff - s_last_ff;
               s_last_in = err_ff;
            end
            ALU_S_INT: begin
               if (s_sum > S_LIM) begin
                  s_int_in = INT_W'(S_LIM);
               end else if (s_sum < -S_LIM) begin
                  s_int_in = INT_W'(-S_LIM);
               end else begin
                  s_int_in = s_sum[INT_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   assign result.drive_command = clamp_out(round_shift(acc_ff, SPEED_SHIFT),
                                           cfg.speed_out_max);
   assign result.target_speed  = tspd_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         target_ff <= req_data.target;
         meas_ff   <= req_data.measured_angle;
         rpm_ff    <= req_data.measured_rpm;
      end
      tspd_ff <= tspd_in;
      err_ff  <= err_in;
      dif_ff  <= dif_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_last_ff <= '0;
         a_int_ff  <= '0;
         s_last_ff <= '0;
         s_int_ff  <= '0;
      end else begin
         a_last_ff <= a_last_in;
         a_int_ff  <= a_int_in;
         s_last_ff <= s_last_in;
         s_int_ff  <= s_int_in;
      end
   end

endmodule

/* design/caspid_seq.sv */
// Sequencer of the cascaded angle/speed PID: step counter over the control store,
// mode branch, input handshake and the result register. Uses caspid_pkg.
module caspid_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output caspid_pkg::rsp_type       rsp_data,
   input  caspid_pkg::rsp_type       dp_result,
   output caspid_pkg::dp_ctrl_type   dp_ctrl
);
   import caspid_pkg::*;

   seq_state_type   state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            mode_ff, mode_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff;
   ctrl_word_type   word;
   logic            accept;
   logic            out_free;
   logic            finish;
   logic            step_en;

   assign word     = ucode_rom(pc_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Outputs of the control state machine.
   always_comb begin
      req_stall = 1'b1;
      step_en   = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_RUN: begin
            // hold on the last step until the result register frees up
            finish  = word.last && out_free;
            step_en = !word.last || out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Next state, step counter and mode.
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      mode_in  = mode_ff;
      case (state_ff)
         ST_IDLE: begin
            pc_in = '0;
            if (accept) begin
               state_in = ST_RUN;
               mode_in  = req_mode;
            end
         end
         ST_RUN: begin
            if (finish) begin
               state_in = ST_IDLE;
               pc_in    = '0;
            end else if (step_en) begin
               if (word.br_speed && mode_ff) begin
                  pc_in = word.br_target;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            pc_in    = '0;
         end
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   assign dp_ctrl.load    = accept;
   assign dp_ctrl.step_en = step_en;
   assign dp_ctrl.word    = word;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= dp_result;
      end
   end

`ifndef SYNTHESIS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN) && (pc_ff == '0))
      else $error("accepted word did not start the program at step zero");

   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (pc_ff <= PC_LAST))
      else $error("step counter ran past the end of the program");

   a_result_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result lost or overwritten");

   a_idle_no_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !step_en && !finish)
      else $error("datapath stepped while idle");
`endif

endmodule

/* design/cascaded_angle_speed_pid.sv */
// Cascaded angle/speed PID controller, top level.
// Usage:
//   req_*  : one word per control tick (mode, target, measured angle, measured rpm).
//            A word is taken at a clock edge with req_valid high and req_stall low.
//   rsp_*  : one word per tick (drive command, target speed), taken at an edge
//            with rsp_valid high and rsp_stall low.
//   csr_*  : register writes (index, data); csr_ready is always high. Write only
//            while no tick is in flight.
// Timing: a control store of 15 steps drives one shared 32x17 multiplier and an
//   accumulator. Angle cascade mode runs every step; speed-only mode branches from
//   the first step past the angle steps. req_stall stays high while a tick runs and
//   drops the cycle after its result is written, so a new word is taken only once
//   the tick before it has finished.
// Stall: a result waits in the output register; the next tick runs meanwhile and
//   holds on its last step until that register is free.
// Reset (synchronous): clears the gains, clamps, loop state and any pending result.
// Depends on caspid_pkg, caspid_csr, caspid_seq and caspid_dp.
module cascaded_angle_speed_pid (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  caspid_pkg::req_type               req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output caspid_pkg::rsp_type               rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [caspid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_wdata
);
   import caspid_pkg::*;

   cfg_type     cfg;
   dp_ctrl_type dp_ctrl;
   rsp_type     dp_result;

   caspid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   caspid_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_mode  (req_data.mode),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .dp_result (dp_result),
      .dp_ctrl   (dp_ctrl)
   );

   caspid_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (dp_ctrl),
      .req_data (req_data),
      .cfg      (cfg),
      .result   (dp_result)
   );

endmodule
